[design/bsr_pkg.sv]
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and microcode for the banker's safety engine
// Item kinds, result codes, sequencer step addresses and the control store.
// ----------------------------------------------------------------------------
package bsr_pkg;

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_AVAIL = 2'd1,
    K_REQ   = 2'd2,
    K_CHECK = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_EXCEEDS  = 3'd1,
    ST_WAIT     = 3'd2,
    ST_UNSAFE   = 3'd3,
    ST_SEQ      = 3'd4,
    ST_NOT_SAFE = 3'd5
  } status_t;

  // datapath operation of one step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_RD_P,
    OP_RD_Q,
    OP_REQ_CMP,
    OP_J_INC,
    OP_INIT_TRIAL,
    OP_INIT_CHECK,
    OP_RELEASE,
    OP_FINISH,
    OP_Q_STEP,
    OP_CLR_FOUND,
    OP_COMMIT_WR,
    OP_COMMIT_AV,
    OP_EMIT,
    OP_EMIT_SEQ,
    OP_END
  } op_t;

  // jump condition of one step
  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_EXCEED,
    C_WAIT,
    C_FIN_Q,
    C_NO_FIT,
    C_J_MORE,
    C_Q_MORE,
    C_ALL_DONE,
    C_NOT_FOUND,
    C_CHECK,
    C_K_MORE
  } cond_t;

  // control store addresses
  typedef enum logic [4:0] {
    S_IDLE         = 5'd0,
    S_REQ_RD       = 5'd1,
    S_REQ_CMP      = 5'd2,
    S_REQ_NXT      = 5'd3,
    S_REQ_WAIT     = 5'd4,
    S_TRIAL_INIT   = 5'd5,
    S_CHK_INIT     = 5'd6,
    S_SCAN_TEST    = 5'd7,
    S_FIT_RD       = 5'd8,
    S_FIT_CMP      = 5'd9,
    S_FIT_NXT      = 5'd10,
    S_REL_RD       = 5'd11,
    S_REL_ADD      = 5'd12,
    S_REL_NXT      = 5'd13,
    S_FINISH       = 5'd14,
    S_SCAN_NEXT    = 5'd15,
    S_PASS_END     = 5'd16,
    S_PASS_FAIL    = 5'd17,
    S_PASS_AGAIN   = 5'd18,
    S_SCAN_OK      = 5'd19,
    S_COMMIT_RD    = 5'd20,
    S_COMMIT_WR    = 5'd21,
    S_COMMIT_NXT   = 5'd22,
    S_COMMIT_AV    = 5'd23,
    S_EMIT_GRANT   = 5'd24,
    S_SCAN_BAD     = 5'd25,
    S_EMIT_UNSAFE  = 5'd26,
    S_EMIT_EXC     = 5'd27,
    S_EMIT_WAIT    = 5'd28,
    S_EMIT_NOTSAFE = 5'd29,
    S_EMIT_SEQ     = 5'd30,
    S_END          = 5'd31
  } step_t;

  typedef struct packed {
    op_t     op;
    cond_t   cond;
    step_t   target;
    status_t status;
  } ctrl_t;

  function automatic ctrl_t bsr_ucode(input step_t s);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_NONE, target: S_IDLE, status: ST_GRANTED};
    unique case (s)
      S_IDLE:         w = '{OP_NOP,        C_NONE,      S_IDLE,         ST_GRANTED};
      S_REQ_RD:       w = '{OP_RD_P,       C_NONE,      S_IDLE,         ST_GRANTED};
      S_REQ_CMP:      w = '{OP_REQ_CMP,    C_EXCEED,    S_EMIT_EXC,     ST_GRANTED};
      S_REQ_NXT:      w = '{OP_J_INC,      C_J_MORE,    S_REQ_RD,       ST_GRANTED};
      S_REQ_WAIT:     w = '{OP_NOP,        C_WAIT,      S_EMIT_WAIT,    ST_GRANTED};
      S_TRIAL_INIT:   w = '{OP_INIT_TRIAL, C_ALWAYS,    S_SCAN_TEST,    ST_GRANTED};
      S_CHK_INIT:     w = '{OP_INIT_CHECK, C_NONE,      S_IDLE,         ST_GRANTED};
      S_SCAN_TEST:    w = '{OP_NOP,        C_FIN_Q,     S_SCAN_NEXT,    ST_GRANTED};
      S_FIT_RD:       w = '{OP_RD_Q,       C_NONE,      S_IDLE,         ST_GRANTED};
      S_FIT_CMP:      w = '{OP_NOP,        C_NO_FIT,    S_SCAN_NEXT,    ST_GRANTED};
      S_FIT_NXT:      w = '{OP_J_INC,      C_J_MORE,    S_FIT_RD,       ST_GRANTED};
      S_REL_RD:       w = '{OP_RD_Q,       C_NONE,      S_IDLE,         ST_GRANTED};
      S_REL_ADD:      w = '{OP_RELEASE,    C_NONE,      S_IDLE,         ST_GRANTED};
      S_REL_NXT:      w = '{OP_J_INC,      C_J_MORE,    S_REL_RD,       ST_GRANTED};
      S_FINISH:       w = '{OP_FINISH,     C_NONE,      S_IDLE,         ST_GRANTED};
      S_SCAN_NEXT:    w = '{OP_Q_STEP,     C_Q_MORE,    S_SCAN_TEST,    ST_GRANTED};
      S_PASS_END:     w = '{OP_NOP,        C_ALL_DONE,  S_SCAN_OK,      ST_GRANTED};
      S_PASS_FAIL:    w = '{OP_CLR_FOUND,  C_NOT_FOUND, S_SCAN_BAD,     ST_GRANTED};
      S_PASS_AGAIN:   w = '{OP_NOP,        C_ALWAYS,    S_SCAN_TEST,    ST_GRANTED};
      S_SCAN_OK:      w = '{OP_NOP,        C_CHECK,     S_EMIT_SEQ,     ST_GRANTED};
      S_COMMIT_RD:    w = '{OP_RD_P,       C_NONE,      S_IDLE,         ST_GRANTED};
      S_COMMIT_WR:    w = '{OP_COMMIT_WR,  C_NONE,      S_IDLE,         ST_GRANTED};
      S_COMMIT_NXT:   w = '{OP_J_INC,      C_J_MORE,    S_COMMIT_RD,    ST_GRANTED};
      S_COMMIT_AV:    w = '{OP_COMMIT_AV,  C_NONE,      S_IDLE,         ST_GRANTED};
      S_EMIT_GRANT:   w = '{OP_EMIT,       C_ALWAYS,    S_END,          ST_GRANTED};
      S_SCAN_BAD:     w = '{OP_NOP,        C_CHECK,     S_EMIT_NOTSAFE, ST_GRANTED};
      S_EMIT_UNSAFE:  w = '{OP_EMIT,       C_ALWAYS,    S_END,          ST_UNSAFE};
      S_EMIT_EXC:     w = '{OP_EMIT,       C_ALWAYS,    S_END,          ST_EXCEEDS};
      S_EMIT_WAIT:    w = '{OP_EMIT,       C_ALWAYS,    S_END,          ST_WAIT};
      S_EMIT_NOTSAFE: w = '{OP_EMIT,       C_ALWAYS,    S_END,          ST_NOT_SAFE};
      S_EMIT_SEQ:     w = '{OP_EMIT_SEQ,   C_K_MORE,    S_EMIT_SEQ,     ST_SEQ};
      S_END:          w = '{OP_END,        C_ALWAYS,    S_IDLE,         ST_GRANTED};
    endcase
    return w;
  endfunction

endpackage

[design/bsr_ram.sv]
// ----------------------------------------------------------------------------
// bsr_ram: single-port RAM with registered read
// One address per cycle, write when we is high, read data is registered and follows in the next cycle.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[design/bankers_safety_and_request.sv]
// ----------------------------------------------------------------------------
// bankers_safety_and_request: banker's deadlock-avoidance engine
// Claim/allocation table in RAM, available vector in registers, and a
// microcoded sequencer that runs the request checks and the safety scan.
// ----------------------------------------------------------------------------
// Load, set-available and unmarked request items are done in the idle step.
// Marked request: a claim check over each resource, an availability check,
//   then the scan. Scan: passes repeat while a process finishes, up to
//   NUM_PROCESSES passes. A grant then commits the pending units to the
//   table and the available vector; a check emits one result per cycle
//   while out_ready is high. One item is in work at a time.
// Reset (rst, synchronous): tables, available vector and control cleared.
module bankers_safety_and_request #(
  parameter int NUM_PROCESSES = 8,
  parameter int NUM_RESOURCES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [2:0] process,
  input  logic [1:0] resource,
  input  logic [7:0] amount,
  input  logic [7:0] claim,
  input  logic       last_element,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status,
  output logic [2:0] seq_process,
  output logic       last
);

  import bsr_pkg::*;

  // index widths follow the table shape; work vector is sized so that the
  // available units plus every held unit never overflow
  localparam int PW    = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int RW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int CW    = $clog2(NUM_PROCESSES + 1);
  localparam int WW    = 8 + $clog2(NUM_PROCESSES + 1);
  localparam int DEPTH = NUM_PROCESSES * NUM_RESOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer
  step_t pc;
  step_t pc_next;
  ctrl_t cw;
  logic  take;
  logic  hold;
  logic  slot_free;
  logic  accept;

  // scan and request control
  logic [PW-1:0]      p_idx;
  logic [PW-1:0]      q_idx;
  logic [PW-1:0]      k_idx;
  logic [RW-1:0]      j_idx;
  logic [CW-1:0]      count;
  logic [NUM_PROCESSES-1:0] fin;
  logic               found;
  logic               wait_flag;
  logic               check_mode;

  // vectors held in registers
  logic [7:0]    avail   [NUM_RESOURCES];
  logic [7:0]    pending [NUM_RESOURCES];
  logic [WW-1:0] work    [NUM_RESOURCES];
  logic [PW-1:0] seq     [NUM_PROCESSES];

  // claim/held table: RAM word is {claim, held}, valid bit per entry
  logic [DEPTH-1:0] ent_valid;
  logic             rd_valid;
  logic [15:0]      rd_word;
  logic [15:0]      ram_wdata;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [PW-1:0]    a_proc;
  logic [RW-1:0]    a_res;

  logic [7:0] entry_claim;
  logic [7:0] entry_held;
  logic [7:0] scan_held;
  logic [8:0] need_req;
  logic [8:0] need_scan;
  logic       exceed;
  logic       no_fit;
  logic       proc_ok;
  logic       res_ok;
  logic       j_last;
  logic       q_last;
  logic       k_last;

  assign cw        = bsr_ucode(pc);
  assign in_ready  = (pc == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign proc_ok = int'(process) < NUM_PROCESSES;
  assign res_ok  = int'(resource) < NUM_RESOURCES;
  assign j_last  = (j_idx == RW'(NUM_RESOURCES - 1));
  assign q_last  = (q_idx == PW'(NUM_PROCESSES - 1));
  assign k_last  = (k_idx == PW'(NUM_PROCESSES - 1));

  // ---------------------------------------------------------------------
  // Table access: idle loads come straight from the item, otherwise the
  // step picks the requesting process or the scanned process.
  // ---------------------------------------------------------------------
  always_comb begin
    if (pc == S_IDLE) begin
      a_proc = PW'(process);
      a_res  = RW'(resource);
    end else begin
      a_proc = (cw.op == OP_RD_Q) ? q_idx : p_idx;
      a_res  = j_idx;
    end
  end

  assign ram_addr = AW'(int'(a_proc) * NUM_RESOURCES + int'(a_res));

  // an entry never written reads as zero
  assign entry_claim = rd_valid ? rd_word[15:8] : 8'd0;
  assign entry_held  = rd_valid ? rd_word[7:0]  : 8'd0;

  // trial allocation is not copied: the requesting row is seen with the
  // pending units added while a request scan runs
  assign scan_held = (!check_mode && q_idx == p_idx) ? (entry_held + pending[j_idx])
                                                     : entry_held;

  // needs are signed: a claim below holding gives a negative need
  assign need_req  = {1'b0, entry_claim} - {1'b0, entry_held};
  assign need_scan = {1'b0, entry_claim} - {1'b0, scan_held};
  assign exceed    = $signed({1'b0, pending[j_idx]}) > $signed(need_req);
  assign no_fit    = $signed({{(WW - 8){need_scan[8]}}, need_scan})
                   > $signed({1'b0, work[j_idx]});

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {claim, amount};
    if (accept && kind_t'(kind) == K_LOAD && proc_ok && res_ok) begin
      ram_we = 1'b1;
    end else if (cw.op == OP_COMMIT_WR) begin
      ram_we    = 1'b1;
      ram_wdata = {entry_claim, entry_held + pending[j_idx]};
    end
  end

  bsr_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rd_word)
  );

  // ---------------------------------------------------------------------
  // Sequencer: evaluate the step's jump condition; emit steps hold while
  // the output register is still full.
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (cw.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_EXCEED:    take = exceed;
      C_WAIT:      take = wait_flag;
      C_FIN_Q:     take = fin[q_idx];
      C_NO_FIT:    take = no_fit;
      C_J_MORE:    take = !j_last;
      C_Q_MORE:    take = !q_last;
      C_ALL_DONE:  take = (count == CW'(NUM_PROCESSES));
      C_NOT_FOUND: take = !found;
      C_CHECK:     take = check_mode;
      C_K_MORE:    take = !k_last;
      default:     take = 1'b0;
    endcase

    hold = (cw.op == OP_EMIT || cw.op == OP_EMIT_SEQ) && !slot_free;

    if (pc == S_IDLE) begin
      pc_next = S_IDLE;
      if (accept) begin
        unique case (kind_t'(kind))
          K_LOAD:  pc_next = S_IDLE;
          K_AVAIL: pc_next = S_IDLE;
          K_REQ: begin
            if (last_element) begin
              pc_next = proc_ok ? S_REQ_RD : S_EMIT_EXC;
            end
          end
          K_CHECK: pc_next = S_CHK_INIT;
        endcase
      end
    end else if (hold) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = cw.target;
    end else begin
      pc_next = step_t'(pc + 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------------------------------------------------------------
  // Control registers and the available vector
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid  <= '0;
      rd_valid   <= 1'b0;
      fin        <= '0;
      count      <= '0;
      found      <= 1'b0;
      wait_flag  <= 1'b0;
      check_mode <= 1'b0;
      q_idx      <= '0;
      j_idx      <= '0;
      k_idx      <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        avail[i] <= 8'd0;
      end
    end else begin
      rd_valid <= ent_valid[ram_addr];
      if (ram_we) begin
        ent_valid[ram_addr] <= 1'b1;
      end
      // drop the result once taken; a new one may load in the same cycle
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        unique case (kind_t'(kind))
          K_LOAD: begin
          end
          K_AVAIL: begin
            if (res_ok) begin
              avail[RW'(resource)] <= amount;
            end
          end
          K_REQ: begin
            check_mode <= 1'b0;
            wait_flag  <= 1'b0;
            j_idx      <= '0;
          end
          K_CHECK: begin
            check_mode <= 1'b1;
          end
        endcase
      end else if (!hold) begin
        unique case (cw.op)
          OP_REQ_CMP: begin
            wait_flag <= wait_flag | (pending[j_idx] > avail[j_idx]);
          end
          OP_J_INC: begin
            j_idx <= j_last ? '0 : j_idx + 1'b1;
          end
          OP_INIT_TRIAL, OP_INIT_CHECK: begin
            fin   <= '0;
            count <= '0;
            found <= 1'b0;
            q_idx <= '0;
            j_idx <= '0;
            k_idx <= '0;
          end
          OP_FINISH: begin
            fin[q_idx] <= 1'b1;
            count      <= count + 1'b1;
            found      <= 1'b1;
          end
          OP_Q_STEP: begin
            j_idx <= '0;
            q_idx <= q_last ? '0 : q_idx + 1'b1;
          end
          OP_CLR_FOUND: begin
            found <= 1'b0;
          end
          OP_COMMIT_AV: begin
            for (int i = 0; i < NUM_RESOURCES; i++) begin
              avail[i] <= avail[i] - pending[i];
            end
          end
          OP_EMIT: begin
            out_valid <= 1'b1;
          end
          OP_EMIT_SEQ: begin
            out_valid <= 1'b1;
            if (!k_last) begin
              k_idx <= k_idx + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers: pending request, work vector, safe order, result
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      if (kind_t'(kind) == K_REQ) begin
        p_idx <= PW'(process);
        if (res_ok) begin
          pending[RW'(resource)] <= amount;
        end
      end
    end else if (!hold) begin
      unique case (cw.op)
        OP_INIT_TRIAL: begin
          for (int i = 0; i < NUM_RESOURCES; i++) begin
            work[i] <= WW'(avail[i] - pending[i]);
          end
        end
        OP_INIT_CHECK: begin
          for (int i = 0; i < NUM_RESOURCES; i++) begin
            work[i] <= WW'(avail[i]);
          end
        end
        OP_RELEASE: begin
          work[j_idx] <= work[j_idx] + WW'(scan_held);
        end
        OP_FINISH: begin
          seq[count[PW-1:0]] <= q_idx;
        end
        OP_EMIT: begin
          status      <= cw.status;
          seq_process <= 3'd0;
          last        <= 1'b1;
        end
        OP_EMIT_SEQ: begin
          status      <= ST_SEQ;
          seq_process <= 3'(seq[k_idx]);
          last        <= k_last;
        end
        OP_END: begin
          // a decision always leaves the request vector cleared
          if (!check_mode) begin
            for (int i = 0; i < NUM_RESOURCES; i++) begin
              pending[i] <= 8'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_scan_ok_all_finished: assert property (@(posedge clk) disable iff (rst)
    (pc == S_SCAN_OK) |-> (fin == {NUM_PROCESSES{1'b1}}))
    else $error("safe scan ended with an unfinished process");

  a_seq_full_count: assert property (@(posedge clk) disable iff (rst)
    (pc == S_EMIT_SEQ) |-> (check_mode && count == CW'(NUM_PROCESSES)))
    else $error("safe order emitted without a full sequence");

  a_commit_on_request: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_COMMIT_WR || cw.op == OP_COMMIT_AV) |-> !check_mode)
    else $error("commit during a check run");

  a_check_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && kind_t'(kind) == K_CHECK) |=> (pc == S_CHK_INIT))
    else $error("check item did not start the scan");

endmodule

[tb/bankers_safety_and_request_test.sv]
// ----------------------------------------------------------------------------
// bankers_safety_and_request_test: self-checking bench for the banker's engine
// Drives load, set-available, request and check items through the input
// handshake, predicts every decision and safe sequence in a model of its own,
// and compares each result field by field as it leaves the block.
// ----------------------------------------------------------------------------
module bankers_safety_and_request_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsr_pkg::*;

  localparam int NPROC       = 8;
  localparam int NRES        = 4;
  localparam int RESET_LEN   = 9;
  localparam int DRILL_LEN   = 25;
  localparam int ITEM_TOTAL  = 235;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 29;
  localparam int SETTLE      = 60;
  localparam int CYCLE_LIMIT = 2_000_000;

  // one input item, as the block sees it
  typedef struct packed {
    kind_t      kind;
    logic [2:0] proc;
    logic [1:0] res;
    logic [7:0] amount;
    logic [7:0] claim;
    logic       mark;
  } bank_item_t;

  // one result item
  typedef struct packed {
    status_t    status;
    logic [2:0] seq;
    logic       last;
  } answer_t;

  // a row of the directed table; typed rows carry their own single answer
  typedef struct packed {
    bank_item_t item;
    logic       typed;
    status_t    want;
  } drill_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  kind_t      item_kind = K_LOAD;
  logic [2:0] item_proc = '0;
  logic [1:0] item_res = '0;
  logic [7:0] item_amount = '0;
  logic [7:0] item_claim = '0;
  logic       item_mark = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] res_status;
  logic [2:0] res_seq;
  logic       res_last;

  // predicted state of the engine
  logic [7:0] claim_tab [NPROC][NRES];
  logic [7:0] held_tab  [NPROC][NRES];
  logic [7:0] avail_vec [NRES];
  logic [7:0] req_vec   [NRES];
  // scratch copy for the trial allocation and the order the scan finds
  logic [7:0] trial_avail [NRES];
  logic [7:0] trial_held  [NPROC][NRES];
  logic [2:0] scan_order  [NPROC];

  answer_t answer_q [$];
  int      fails = 0;
  int      items_sent = 0;
  int      cycles = 0;
  int      tx_idle_pct = IDLE_PCT;
  int      rx_idle_pct = IDLE_PCT;
  bit      hold_asked = 1'b0;
  int      rx_hold_left = 0;

  drill_row_t drill [DRILL_LEN];

  bankers_safety_and_request dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (item_kind),
    .process      (item_proc),
    .resource     (item_res),
    .amount       (item_amount),
    .claim        (item_claim),
    .last_element (item_mark),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (res_status),
    .seq_process  (res_seq),
    .last         (res_last)
  );

  always #1 clk = ~clk;

  // Safety scan over the trial copy. Each pass walks processes in index
  // order and a process that fits releases its units at once, so later
  // processes in the same pass already see the larger work vector.
  function automatic bit safety_pass_ok();
    int work [NRES];
    bit done [NPROC];
    int count;
    int p;
    int j;
    bit found;
    bit fits;
    for (j = 0; j < NRES; j++) work[j] = int'(trial_avail[j]);
    for (p = 0; p < NPROC; p++) done[p] = 1'b0;
    count = 0;
    while (count < NPROC) begin
      found = 1'b0;
      for (p = 0; p < NPROC; p++) begin
        if (!done[p]) begin
          fits = 1'b1;
          // a holding above the claim gives a negative need: always fits
          for (j = 0; j < NRES; j++)
            if (int'(claim_tab[p][j]) - int'(trial_held[p][j]) > work[j]) fits = 1'b0;
          if (fits) begin
            for (j = 0; j < NRES; j++) work[j] += int'(trial_held[p][j]);
            scan_order[count] = 3'(p);
            count++;
            done[p] = 1'b1;
            found = 1'b1;
          end
        end
      end
      if (!found) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Decide a marked request: claim first, then availability, then trial.
  function automatic status_t decide_request(input logic [2:0] p);
    int j;
    for (j = 0; j < NRES; j++)
      if (int'(req_vec[j]) > int'(claim_tab[p][j]) - int'(held_tab[p][j])) return ST_EXCEEDS;
    for (j = 0; j < NRES; j++)
      if (req_vec[j] > avail_vec[j]) return ST_WAIT;
    trial_held = held_tab;
    for (j = 0; j < NRES; j++) begin
      trial_avail[j] = avail_vec[j] - req_vec[j];
      trial_held[p][j] = held_tab[p][j] + req_vec[j];
    end
    if (!safety_pass_ok()) return ST_UNSAFE;
    // safe: commit the trial
    avail_vec = trial_avail;
    held_tab  = trial_held;
    return ST_GRANTED;
  endfunction

  // Advance the predicted state by one accepted item and queue its answers.
  task automatic predict_answers(input bank_item_t it);
    int k;
    case (it.kind)
      K_LOAD: begin
        claim_tab[it.proc][it.res] = it.claim;
        held_tab[it.proc][it.res]  = it.amount;
      end
      K_AVAIL: avail_vec[it.res] = it.amount;
      K_REQ: begin
        req_vec[it.res] = it.amount;
        if (it.mark) begin
          answer_q.push_back('{decide_request(it.proc), 3'd0, 1'b1});
          // elements not sent before the next decision ask for nothing
          for (k = 0; k < NRES; k++) req_vec[k] = '0;
        end
      end
      default: begin
        trial_avail = avail_vec;
        trial_held  = held_tab;
        if (safety_pass_ok()) begin
          for (k = 0; k < NPROC; k++)
            answer_q.push_back('{ST_SEQ, scan_order[k], (k == NPROC - 1)});
        end else begin
          answer_q.push_back('{ST_NOT_SAFE, 3'd0, 1'b1});
        end
      end
    endcase
  endtask

  // Offer one item: idle at random first, then hold valid until it is taken.
  task automatic offer(input bank_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    item_kind   <= it.kind;
    item_proc   <= it.proc;
    item_res    <= it.res;
    item_amount <= it.amount;
    item_claim  <= it.claim;
    item_mark   <= it.mark;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_answers(it);
  endtask

  // Drop valid and hold the input until every queued answer has come out.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // One random group: a load, a set, a whole request sequence or a check.
  // Ignored fields carry noise throughout.
  task automatic send_random_group();
    bank_item_t it;
    int pick;
    int roll;
    int n;
    int first;
    int need;
    int j;
    it.kind   = K_LOAD;
    it.proc   = 3'($urandom);
    it.res    = 2'($urandom);
    it.amount = 8'($urandom);
    it.claim  = 8'($urandom);
    it.mark   = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 22) begin
      // mostly small, consistent entries; now and then a wild one
      if ($urandom_range(9) != 0) begin
        it.claim  = 8'($urandom_range(12));
        it.amount = 8'($urandom_range(int'(it.claim)));
      end
      offer(it);
    end else if (pick < 32) begin
      it.kind = K_AVAIL;
      if ($urandom_range(6) != 0) it.amount = 8'($urandom_range(16));
      offer(it);
    end else if (pick < 80) begin
      // well-formed request: consecutive resources, last one marked,
      // amounts shaped by the remaining need so that the scan runs
      it.kind = K_REQ;
      n = $urandom_range(1, NRES);
      first = $urandom_range(NRES - 1);
      for (j = 0; j < n; j++) begin
        it.res = 2'((first + j) % NRES);
        it.claim = 8'($urandom);
        need = int'(claim_tab[it.proc][it.res]) - int'(held_tab[it.proc][it.res]);
        roll = $urandom_range(9);
        if (roll < 7) it.amount = (need > 0) ? 8'($urandom_range(need)) : 8'd0;
        else if (roll < 9) it.amount = 8'($urandom_range(8));
        else it.amount = 8'($urandom);
        // a broken sequence now and then leaves its elements pending
        it.mark = (j == n - 1) && ($urandom_range(19) != 0);
        offer(it);
      end
    end else begin
      it.kind = K_CHECK;
      offer(it);
    end
  endtask

  // Receiver: random back-pressure, plus long hold-offs counted here.
  always @(posedge clk) begin
    if (hold_asked) begin
      hold_asked = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result checker: compare each accepted result with the oldest answer.
  always @(posedge clk) begin : result_check
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result: status=%0d seq_process=%0d last=%0d",
               res_status, res_seq, res_last);
        fails++;
      end else begin
        want = answer_q.pop_front();
        if (res_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_status);
          fails++;
        end
        if (res_seq !== want.seq) begin
          $error("seq_process: expected %0d, got %0d", want.seq, res_seq);
          fails++;
        end
        if (res_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, res_last);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bankers_safety_and_request_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int p;
    int r;
    for (p = 0; p < NPROC; p++)
      for (r = 0; r < NRES; r++) begin
        claim_tab[p][r] = '0;
        held_tab[p][r]  = '0;
      end
    for (r = 0; r < NRES; r++) begin
      avail_vec[r] = '0;
      req_vec[r]   = '0;
    end

    // Directed rows. Typed answers hold only where they follow at once from
    // reset, the extremes or a plain error; the rest go through the model.
    drill = '{
      // empty tables: a zero request is granted, any non-zero one exceeds
      '{'{K_REQ,   3'd3, 2'd0, 8'd0,   8'd0,   1'b1}, 1'b1, ST_GRANTED},
      '{'{K_REQ,   3'd5, 2'd2, 8'd255, 8'd255, 1'b1}, 1'b1, ST_EXCEEDS},
      '{'{K_CHECK, 3'd7, 2'd3, 8'd255, 8'd255, 1'b1}, 1'b0, ST_GRANTED},
      // full claim with nothing available: must wait, then granted
      '{'{K_LOAD,  3'd0, 2'd0, 8'd0,   8'd255, 1'b1}, 1'b0, ST_GRANTED},
      '{'{K_REQ,   3'd0, 2'd0, 8'd255, 8'd0,   1'b1}, 1'b1, ST_WAIT},
      '{'{K_AVAIL, 3'd6, 2'd0, 8'd255, 8'd255, 1'b1}, 1'b0, ST_GRANTED},
      '{'{K_REQ,   3'd0, 2'd0, 8'd255, 8'd170, 1'b1}, 1'b0, ST_GRANTED},
      // holding above the claim: negative need
      '{'{K_LOAD,  3'd7, 2'd3, 8'd200, 8'd10,  1'b0}, 1'b0, ST_GRANTED},
      '{'{K_REQ,   3'd7, 2'd3, 8'd1,   8'd85,  1'b1}, 1'b1, ST_EXCEEDS},
      '{'{K_CHECK, 3'd0, 2'd0, 8'd0,   8'd0,   1'b0}, 1'b0, ST_GRANTED},
      // a later process in the pass frees what an earlier one lacks
      '{'{K_LOAD,  3'd4, 2'd1, 8'd3,   8'd3,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_LOAD,  3'd1, 2'd1, 8'd0,   8'd4,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_AVAIL, 3'd1, 2'd1, 8'd1,   8'd0,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_CHECK, 3'd2, 2'd1, 8'd15,  8'd240, 1'b1}, 1'b0, ST_GRANTED},
      // three processes share resource 2; one unit more starves them
      '{'{K_LOAD,  3'd2, 2'd2, 8'd3,   8'd9,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_LOAD,  3'd3, 2'd2, 8'd2,   8'd4,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_LOAD,  3'd4, 2'd2, 8'd2,   8'd7,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_AVAIL, 3'd0, 2'd2, 8'd3,   8'd0,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_CHECK, 3'd0, 2'd0, 8'd0,   8'd0,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_REQ,   3'd2, 2'd2, 8'd1,   8'd0,   1'b1}, 1'b1, ST_UNSAFE},
      '{'{K_CHECK, 3'd5, 2'd1, 8'd0,   8'd0,   1'b1}, 1'b0, ST_GRANTED},
      '{'{K_AVAIL, 3'd0, 2'd2, 8'd1,   8'd0,   1'b0}, 1'b0, ST_GRANTED},
      '{'{K_CHECK, 3'd0, 2'd0, 8'd0,   8'd0,   1'b0}, 1'b1, ST_NOT_SAFE},
      // an unmarked element stays pending; unsent ones ask for zero
      '{'{K_REQ,   3'd1, 2'd1, 8'd1,   8'd255, 1'b0}, 1'b0, ST_GRANTED},
      '{'{K_REQ,   3'd1, 2'd0, 8'd0,   8'd0,   1'b1}, 1'b0, ST_GRANTED}
    };

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DRILL_LEN; i++) begin
      offer(drill[i].item);
      // the row's own answer stands in for the predicted one
      if (drill[i].typed) answer_q[answer_q.size() - 1] = '{drill[i].want, 3'd0, 1'b1};
    end

    // hold the input until the directed answers are all out
    drain_answers();

    while (items_sent < ITEM_TOTAL) begin
      // groups started at 80 to 83 items ask for a long hold-off while items keep coming
      if (items_sent >= 80 && items_sent < 84) hold_asked = 1'b1;
      // a stretch with no idling on either side
      if (items_sent >= 130 && items_sent < 170) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
      end
      send_random_group();
    end

    drain_answers();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) begin
      $display("bankers_safety_and_request_test: clean");
    end else begin
      $display("bankers_safety_and_request_test: errors");
    end
    $finish;
  end

endmodule
